/* design/cff_pkg.sv */
// Shared constants, codes and types for the complex FIR filter.
package cff_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_TAPS_DEFAULT    = 64;
  localparam int SAMPLE_BITS_DEFAULT = 16;
  localparam int TAP_BITS_DEFAULT    = 16;

  // Fixed field widths.
  localparam int OUT_BITS       = 38;
  localparam int TAP_INDEX_BITS = 6;
  localparam int TAPS_CFG_BITS  = 7;

  localparam logic [TAPS_CFG_BITS-1:0] TAPS_RESET = 7'd64;

  // Input opcodes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Queue depths.
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int RES_FIFO_DEPTH = 2;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH
  } back_state_t;

endpackage

/* design/cff_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/cff_fifo.sv */
// Small register-based first-in first-out queue with show-ahead read.
module cff_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (int'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (int'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + NW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

/* design/cff_front.sv */
// Front end: accepts items, holds the tap-count register and history bookkeeping.
module cff_front #(
  parameter int MAX_TAPS    = cff_pkg::MAX_TAPS_DEFAULT,
  parameter int SAMPLE_BITS = cff_pkg::SAMPLE_BITS_DEFAULT,
  parameter int TAP_BITS    = cff_pkg::TAP_BITS_DEFAULT,
  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int CW    = $clog2(MAX_TAPS + 1),
  localparam int DW    = (TAP_BITS > 2 * SAMPLE_BITS) ? TAP_BITS : 2 * SAMPLE_BITS,
  localparam int CMD_W = 1 + AW + CW + DW
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   opcode,
  input  logic [cff_pkg::TAP_INDEX_BITS-1:0]     tap_index,
  input  logic signed [TAP_BITS-1:0]             tap_value,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  input  logic signed [SAMPLE_BITS-1:0]          sample_q,
  input  logic                                   first_of_block,
  input  logic                                   taps_wr_en,
  input  logic [cff_pkg::TAPS_CFG_BITS-1:0]      taps_wr_data,
  input  logic                                   clearing,
  input  logic                                   cmd_full,
  output logic                                   cmd_push,
  output logic [CMD_W-1:0]                       cmd_data
);

  logic [cff_pkg::TAPS_CFG_BITS-1:0] taps_in_use;
  logic [AW-1:0] hist_ptr;
  logic [AW-1:0] hist_ptr_next;
  logic [CW-1:0] valid_count;
  logic [CW-1:0] vc_base;
  logic [CW-1:0] vc_new;
  logic [CW-1:0] taps_eff;
  logic [CW-1:0] used;
  logic          accept;
  logic          is_sample;
  logic          tap_ok;

  assign full      = cmd_full || clearing;
  assign accept    = push && !full;
  assign is_sample = (opcode == cff_pkg::OP_SAMPLE);
  assign tap_ok    = (int'(tap_index) < MAX_TAPS);

  always_comb begin
    if (int'(taps_in_use) > MAX_TAPS) begin
      taps_eff = CW'(MAX_TAPS);
    end else begin
      taps_eff = CW'(taps_in_use);
    end
    vc_base = first_of_block ? '0 : valid_count;
    vc_new  = (int'(vc_base) < MAX_TAPS) ? vc_base + CW'(1) : vc_base;
    used    = (taps_eff < vc_new) ? taps_eff : vc_new;
    hist_ptr_next = (int'(hist_ptr) == MAX_TAPS - 1) ? '0 : hist_ptr + AW'(1);
  end

  // Samples carry their history slot and tap count; loads carry address and tap.
  always_comb begin
    cmd_push = accept && (is_sample || tap_ok);
    if (is_sample) begin
      cmd_data = {cff_pkg::CMD_SAMPLE, hist_ptr, used, DW'({sample_i, sample_q})};
    end else begin
      cmd_data = {cff_pkg::CMD_LOAD, AW'(tap_index), {CW{1'b0}}, DW'(tap_value)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use <= cff_pkg::TAPS_RESET;
      hist_ptr    <= '0;
      valid_count <= '0;
    end else begin
      if (taps_wr_en) begin
        taps_in_use <= taps_wr_data;
      end
      if (accept && is_sample) begin
        hist_ptr    <= hist_ptr_next;
        valid_count <= vc_new;
      end
    end
  end

endmodule

/* design/cff_back.sv */
// Back end: tap and history memories with one shared complex multiply-accumulate.
module cff_back #(
  parameter int MAX_TAPS    = cff_pkg::MAX_TAPS_DEFAULT,
  parameter int SAMPLE_BITS = cff_pkg::SAMPLE_BITS_DEFAULT,
  parameter int TAP_BITS    = cff_pkg::TAP_BITS_DEFAULT,
  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int CW    = $clog2(MAX_TAPS + 1),
  localparam int DW    = (TAP_BITS > 2 * SAMPLE_BITS) ? TAP_BITS : 2 * SAMPLE_BITS,
  localparam int CMD_W = 1 + AW + CW + DW,
  localparam int RW    = 2 * cff_pkg::OUT_BITS
) (
  input  logic             clk,
  input  logic             rst,
  output logic             clearing,
  input  logic             cmd_empty,
  input  logic [CMD_W-1:0] cmd_data,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output logic [RW-1:0]    res_data
);

  localparam int OB = cff_pkg::OUT_BITS;
  localparam int PW = SAMPLE_BITS + TAP_BITS;
  localparam int MW = (PW > OB) ? PW : OB;
  localparam int HW = 2 * SAMPLE_BITS;

  cff_pkg::back_state_t state;
  cff_pkg::back_state_t state_next;

  cff_pkg::cmd_kind_t kind;
  logic [AW-1:0]      cmd_addr;
  logic [CW-1:0]      cmd_used;
  logic [DW-1:0]      cmd_payload;

  logic [AW-1:0] clr_addr;
  logic [CW-1:0] k;
  logic [AW-1:0] slot;
  logic [CW-1:0] used_r;
  logic          last_issue;
  logic          start;
  logic          issue;

  logic          rd_v;
  logic          rd_last;
  logic          mul_v;
  logic          mul_last;
  logic signed [PW-1:0] prod_i;
  logic signed [PW-1:0] prod_q;
  logic signed [MW-1:0] prod_x_i;
  logic signed [MW-1:0] prod_x_q;
  logic signed [OB-1:0] acc_i;
  logic signed [OB-1:0] acc_q;
  logic signed [OB-1:0] sum_i;
  logic signed [OB-1:0] sum_q;

  logic                coef_we;
  logic [AW-1:0]       coef_waddr;
  logic [TAP_BITS-1:0] coef_wdata;
  logic [TAP_BITS-1:0] coef_rd;
  logic                hist_we;
  logic [HW-1:0]       hist_rd;

  assign kind        = cff_pkg::cmd_kind_t'(cmd_data[CMD_W-1]);
  assign cmd_addr    = cmd_data[CMD_W-2 -: AW];
  assign cmd_used    = cmd_data[DW+CW-1 -: CW];
  assign cmd_payload = cmd_data[DW-1:0];

  assign clearing   = (state == cff_pkg::BK_CLEAR);
  assign last_issue = (k == used_r - CW'(1));

  // Wrap products to the output width before accumulating.
  assign prod_x_i = MW'(prod_i);
  assign prod_x_q = MW'(prod_q);
  assign sum_i    = acc_i + prod_x_i[OB-1:0];
  assign sum_q    = acc_q + prod_x_q[OB-1:0];

  cff_ram #(
    .WIDTH (TAP_BITS),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_we),
    .wr_addr (coef_waddr),
    .wr_data (coef_wdata),
    .rd_en   (issue),
    .rd_addr (k[AW-1:0]),
    .rd_data (coef_rd)
  );

  cff_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (cmd_addr),
    .wr_data (cmd_payload[HW-1:0]),
    .rd_en   (issue),
    .rd_addr (slot),
    .rd_data (hist_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cff_pkg::BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    coef_we    = 1'b0;
    coef_waddr = clr_addr;
    coef_wdata = '0;
    hist_we    = 1'b0;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_data   = '0;
    start      = 1'b0;
    issue      = 1'b0;
    unique case (state)
      cff_pkg::BK_CLEAR: begin
        coef_we = 1'b1;
        if (int'(clr_addr) == MAX_TAPS - 1) begin
          state_next = cff_pkg::BK_IDLE;
        end
      end
      cff_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          if (kind == cff_pkg::CMD_LOAD) begin
            coef_we    = 1'b1;
            coef_waddr = cmd_addr;
            coef_wdata = cmd_payload[TAP_BITS-1:0];
            cmd_pop    = 1'b1;
          end else if (!res_full) begin
            hist_we = 1'b1;
            cmd_pop = 1'b1;
            if (cmd_used == '0) begin
              res_push = 1'b1;
            end else begin
              start      = 1'b1;
              state_next = cff_pkg::BK_SCAN;
            end
          end
        end
      end
      cff_pkg::BK_SCAN: begin
        issue = 1'b1;
        if (last_issue) begin
          state_next = cff_pkg::BK_FLUSH;
        end
      end
      cff_pkg::BK_FLUSH: begin
        if (mul_v && mul_last) begin
          res_push   = 1'b1;
          res_data   = {sum_i, sum_q};
          state_next = cff_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = cff_pkg::BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      rd_v     <= 1'b0;
      mul_v    <= 1'b0;
    end else begin
      if (state == cff_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      rd_v  <= issue;
      mul_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    rd_last  <= issue && last_issue;
    mul_last <= rd_last;
    if (start) begin
      k      <= '0;
      slot   <= cmd_addr;
      used_r <= cmd_used;
      acc_i  <= '0;
      acc_q  <= '0;
    end else begin
      if (issue) begin
        k    <= k + CW'(1);
        slot <= (slot == '0) ? AW'(MAX_TAPS - 1) : slot - AW'(1);
      end
      if (mul_v) begin
        acc_i <= sum_i;
        acc_q <= sum_q;
      end
    end
    if (rd_v) begin
      prod_i <= PW'($signed(hist_rd[HW-1:SAMPLE_BITS])) * PW'($signed(coef_rd));
      prod_q <= PW'($signed(hist_rd[SAMPLE_BITS-1:0])) * PW'($signed(coef_rd));
    end
  end

`ifndef SYNTHESIS
  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == cff_pkg::BK_CLEAR) |-> (!cmd_pop && !res_push))
    else $error("command taken during coefficient clear");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_read_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> ($past(state) == cff_pkg::BK_SCAN))
    else $error("memory read outside tap scan");

  a_flush_ends_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == cff_pkg::BK_SCAN) && last_issue) |=> (state == cff_pkg::BK_FLUSH))
    else $error("tap scan did not end in flush");
`endif

endmodule

/* design/complex_fir_filter.sv */
// Top level of the complex-sample FIR filter with real coefficients.
//
// Input side is a queue: present an item and raise push; it is taken on a
// rising edge with push high and full low. opcode selects a tap load
// (tap_index, tap_value) or a sample (sample_i, sample_q, first_of_block).
// Result side is a queue too: out_i/out_q are valid while empty is low and
// the transaction completes on an edge with pop high. One result per sample.
// taps_wr_en/taps_wr_data set the number of taps applied; write it while idle.
//
// Path: a sample goes from the command queue through the tap scan (memory
// read, multiply, accumulate) to the result queue, or straight in as zero when
// no tap applies; used taps are the smaller of the tap count and the history
// since the last block start. The single complex multiply-accumulate walks one
// tap per cycle and takes no new command until a sample's sum is out. A
// four-entry command queue lets the front keep accepting.
// Reset: the coefficient memory is swept to zero address by address, and
// full stays high during that sweep.
// Stall: with pop low the two-entry result queue fills, the back end holds,
// the command queue fills and full rises; nothing is dropped.
module complex_fir_filter #(
  parameter int MAX_TAPS    = cff_pkg::MAX_TAPS_DEFAULT,
  parameter int SAMPLE_BITS = cff_pkg::SAMPLE_BITS_DEFAULT,
  parameter int TAP_BITS    = cff_pkg::TAP_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  output logic                                    full,
  input  logic                                    opcode,
  input  logic [cff_pkg::TAP_INDEX_BITS-1:0]      tap_index,
  input  logic signed [TAP_BITS-1:0]              tap_value,
  input  logic signed [SAMPLE_BITS-1:0]           sample_i,
  input  logic signed [SAMPLE_BITS-1:0]           sample_q,
  input  logic                                    first_of_block,
  input  logic                                    taps_wr_en,
  input  logic [cff_pkg::TAPS_CFG_BITS-1:0]       taps_wr_data,
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [cff_pkg::OUT_BITS-1:0]     out_i,
  output logic signed [cff_pkg::OUT_BITS-1:0]     out_q
);

  // Command word layout shared by front and back: kind, address, tap count, data.
  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int DW    = (TAP_BITS > 2 * SAMPLE_BITS) ? TAP_BITS : 2 * SAMPLE_BITS;
  localparam int CMD_W = 1 + AW + CW + DW;
  localparam int RW    = 2 * cff_pkg::OUT_BITS;

  logic             clearing;
  logic             cmd_push;
  logic [CMD_W-1:0] cmd_wr_data;
  logic             cmd_full;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_rd_data;
  logic             cmd_empty;
  logic             res_push;
  logic [RW-1:0]    res_wr_data;
  logic             res_full;
  logic [RW-1:0]    res_rd_data;

  // Front: take transactions, track history slot and taps per sample.
  cff_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TAP_BITS    (TAP_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .opcode         (opcode),
    .tap_index      (tap_index),
    .tap_value      (tap_value),
    .sample_i       (sample_i),
    .sample_q       (sample_q),
    .first_of_block (first_of_block),
    .taps_wr_en     (taps_wr_en),
    .taps_wr_data   (taps_wr_data),
    .clearing       (clearing),
    .cmd_full       (cmd_full),
    .cmd_push       (cmd_push),
    .cmd_data       (cmd_wr_data)
  );

  // Decouple front from back so each can stall on its own.
  cff_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (cff_pkg::CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr_data),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd_data),
    .empty   (cmd_empty)
  );

  // Back: write taps and history, run the multiply-accumulate over the taps.
  cff_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TAP_BITS    (TAP_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rd_data),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wr_data)
  );

  // Hold finished results until the receiver pops them.
  cff_fifo #(
    .WIDTH (RW),
    .DEPTH (cff_pkg::RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_wr_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd_data),
    .empty   (empty)
  );

  assign out_i = res_rd_data[RW-1:cff_pkg::OUT_BITS];
  assign out_q = res_rd_data[cff_pkg::OUT_BITS-1:0];

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the complex-sample FIR filter with real taps.
`timescale 1ns / 100ps

module testbench;

  localparam int NTAPS           = cff_pkg::MAX_TAPS_DEFAULT;
  // Cycles to let queued tap loads finish before a register write or the end.
  localparam int SETTLE_CYCLES   = 100;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int PRESSURE_HOLD   = 400;

  typedef struct {
    logic signed [cff_pkg::OUT_BITS-1:0] i;
    logic signed [cff_pkg::OUT_BITS-1:0] q;
  } filt_out_t;

  logic                                      clk;
  logic                                      rst;
  logic                                      push;
  logic                                      full;
  logic                                      opcode;
  logic        [cff_pkg::TAP_INDEX_BITS-1:0] tap_index;
  logic signed [15:0]                        tap_value;
  logic signed [15:0]                        sample_i;
  logic signed [15:0]                        sample_q;
  logic                                      first_of_block;
  logic                                      taps_wr_en;
  logic        [cff_pkg::TAPS_CFG_BITS-1:0]  taps_wr_data;
  logic                                      empty;
  logic                                      pop;
  logic signed [cff_pkg::OUT_BITS-1:0]       out_i;
  logic signed [cff_pkg::OUT_BITS-1:0]       out_q;

  // Filter state as the testbench sees it.
  logic signed [15:0]                        coef_mem [NTAPS];
  logic signed [15:0]                        hist_i   [NTAPS];
  logic signed [15:0]                        hist_q   [NTAPS];
  logic        [5:0]                         hist_wr_ptr;
  int                                        hist_fill;
  logic        [cff_pkg::TAPS_CFG_BITS-1:0]  taps_cfg;

  // Filter outputs still owed by the block, oldest first.
  filt_out_t                                 pending_out [$];

  int err_count   = 0;
  bit tx_idle_on  = 1'b1;
  bit tx_no_idle  = 1'b0;
  bit rx_idle_on  = 1'b1;
  int rx_gap      = 0;
  int rx_hold_cnt = 0;

  complex_fir_filter u_top (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .opcode         (opcode),
    .tap_index      (tap_index),
    .tap_value      (tap_value),
    .sample_i       (sample_i),
    .sample_q       (sample_q),
    .first_of_block (first_of_block),
    .taps_wr_en     (taps_wr_en),
    .taps_wr_data   (taps_wr_data),
    .empty          (empty),
    .pop            (pop),
    .out_i          (out_i),
    .out_q          (out_q)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs; well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clear the predicted state to match the block just out of reset.
  function automatic void fir_model_reset();
    for (int k = 0; k < NTAPS; k++) begin
      coef_mem[k] = '0;
      hist_i[k]   = '0;
      hist_q[k]   = '0;
    end
    hist_wr_ptr = '0;
    hist_fill   = 0;
    taps_cfg    = cff_pkg::TAPS_RESET;
  endfunction

  // Apply one accepted transaction; a sample queues its expected output.
  function automatic void fir_model_step(input logic op, input logic [5:0] idx,
                                         input logic signed [15:0] tv,
                                         input logic signed [15:0] si,
                                         input logic signed [15:0] sq,
                                         input logic fob);
    filt_out_t   res;
    longint      acc_i;
    longint      acc_q;
    int          used;
    logic [5:0]  newest;
    logic [5:0]  slot;
    if (op == cff_pkg::OP_LOAD) begin
      coef_mem[idx] = tv;
      return;
    end
    // A block start forgets everything older than this sample.
    if (fob)
      hist_fill = 0;
    newest         = hist_wr_ptr;
    hist_i[newest] = si;
    hist_q[newest] = sq;
    hist_wr_ptr    = newest + 6'd1;
    if (hist_fill < NTAPS)
      hist_fill++;
    // Clamp the tap count to the store size and to the history on hand.
    used = int'(taps_cfg);
    if (used > NTAPS)
      used = NTAPS;
    if (used > hist_fill)
      used = hist_fill;
    acc_i = 0;
    acc_q = 0;
    for (int k = 0; k < used; k++) begin
      slot  = newest - 6'(k);
      acc_i += longint'(hist_i[slot]) * longint'(coef_mem[k]);
      acc_q += longint'(hist_q[slot]) * longint'(coef_mem[k]);
    end
    res.i = acc_i[cff_pkg::OUT_BITS-1:0];
    res.q = acc_q[cff_pkg::OUT_BITS-1:0];
    pending_out.push_back(res);
  endfunction

  // Random 16-bit word, biased toward the extremes, zero and all ones.
  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: drive pop and check each completed transaction
  // ---------------------------------------------------------------------------

  // Draw a wait after every accepted result; toggle between idling and
  // back-to-back stretches now and then. A hold request keeps pop low.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop && empty === 1'b0) begin
      if ($urandom_range(0, 39) == 0)
        rx_idle_on = !rx_idle_on;
      rx_gap = rx_idle_on ? $urandom_range(0, 16) : 0;
      if (rx_gap != 0 || rx_hold_cnt != 0)
        pop <= 1'b0;
    end else if (pop) begin
      if (rx_hold_cnt != 0)
        pop <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
    end else if (rx_hold_cnt == 0) begin
      pop <= 1'b1;
    end
  end

  // Count down a long receiver hold-off.
  always @(posedge clk) begin
    if (rx_hold_cnt != 0)
      rx_hold_cnt <= rx_hold_cnt - 1;
  end

  // Compare every popped result with the oldest expectation.
  always @(posedge clk) begin
    filt_out_t want;
    if (!rst && pop && empty === 1'b0) begin
      if (pending_out.size() == 0) begin
        report($sformatf("result with nothing expected: out_i=%0d out_q=%0d",
                         out_i, out_q));
      end else begin
        want = pending_out.pop_front();
        if (out_i !== want.i)
          report($sformatf("out_i got %0d expected %0d", out_i, want.i));
        if (out_q !== want.q)
          report($sformatf("out_q got %0d expected %0d", out_q, want.q));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one transaction after a random gap and hold it until accepted.
  // push stays high on return so the next item can follow with no bubble.
  task automatic push_item(input logic op, input logic [5:0] idx,
                           input logic signed [15:0] tv,
                           input logic signed [15:0] si,
                           input logic signed [15:0] sq,
                           input logic fob);
    int gap;
    if ($urandom_range(0, 39) == 0)
      tx_idle_on = !tx_idle_on;
    gap = (tx_idle_on && !tx_no_idle) ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode         <= op;
    tap_index      <= idx;
    tap_value      <= tv;
    sample_i       <= si;
    sample_q       <= sq;
    first_of_block <= fob;
    push           <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    fir_model_step(op, idx, tv, si, sq, fob);
  endtask

  // Drop push, wait for every owed result, then let queued loads drain.
  task automatic settle_idle();
    push <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the tap count while the block is idle.
  task automatic set_taps(input logic [cff_pkg::TAPS_CFG_BITS-1:0] n);
    settle_idle();
    taps_wr_en   <= 1'b1;
    taps_wr_data <= n;
    @(posedge clk);
    taps_wr_en <= 1'b0;
    taps_cfg    = n;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The reset sweep leaves every tap zero, so even full-scale input gives 0.
  task automatic test_after_reset();
    push_item(cff_pkg::OP_SAMPLE, 6'd63, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1);
    push_item(cff_pkg::OP_SAMPLE, 6'd0, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0);
  endtask

  // One tap at both extremes; a load carries junk sample fields and a block
  // mark, both of which must be ignored.
  task automatic test_single_tap_extremes();
    set_taps(7'd1);
    push_item(cff_pkg::OP_LOAD, 6'd0, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1);
    push_item(cff_pkg::OP_SAMPLE, 6'd5, 16'sh1234, 16'sh8000, 16'sh7FFF, 1'b1);
    push_item(cff_pkg::OP_SAMPLE, 6'd0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0);
    push_item(cff_pkg::OP_SAMPLE, 6'd63, 16'sh8000, 16'shFFFF, 16'sh0000, 1'b0);
    push_item(cff_pkg::OP_LOAD, 6'd0, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0);
    push_item(cff_pkg::OP_SAMPLE, 6'd1, 16'sh0001, 16'sh8000, 16'sh8000, 1'b0);
  endtask

  // Full tap count with little history: taps reaching before the block start
  // add nothing, and a second block mark restarts the history mid-stream.
  task automatic test_short_history();
    set_taps(7'd64);
    push_item(cff_pkg::OP_LOAD, 6'd63, 16'sh8000, 16'sh0000, 16'sh0000, 1'b0);
    push_item(cff_pkg::OP_LOAD, 6'd1, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0);
    push_item(cff_pkg::OP_LOAD, 6'd2, 16'shFFFF, 16'sh0000, 16'sh0000, 1'b0);
    push_item(cff_pkg::OP_SAMPLE, 6'd0, 16'sh0000, 16'sh8000, 16'sh8000, 1'b1);
    push_item(cff_pkg::OP_SAMPLE, 6'd0, 16'sh0000, 16'sh7FFF, 16'sh8000, 1'b0);
    push_item(cff_pkg::OP_SAMPLE, 6'd2, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
    push_item(cff_pkg::OP_SAMPLE, 6'd0, 16'sh0000, 16'sh0100, 16'shFF00, 1'b1);
    push_item(cff_pkg::OP_SAMPLE, 6'd0, 16'sh0000, 16'sh8000, 16'sh0001, 1'b0);
  endtask

  // A tap count of zero gives an empty sum.
  task automatic test_zero_taps();
    set_taps(7'd0);
    push_item(cff_pkg::OP_SAMPLE, 6'd0, 16'sh0000, 16'sh8000, 16'sh7FFF, 1'b1);
    push_item(cff_pkg::OP_SAMPLE, 6'd0, 16'sh0000, 16'sh7FFF, 16'sh8000, 1'b0);
  endtask

  // A tap count above the store size acts as the store size.
  task automatic test_taps_above_max();
    set_taps(7'd127);
    push_item(cff_pkg::OP_SAMPLE, 6'd0, 16'sh0000, 16'sh7FFF, 16'sh7FFF, 1'b1);
    push_item(cff_pkg::OP_SAMPLE, 6'd0, 16'sh0000, 16'sh8000, 16'sh8000, 1'b0);
    push_item(cff_pkg::OP_SAMPLE, 6'd0, 16'sh0000, 16'sh1357, 16'shECA8, 1'b0);
  endtask

  // Hold the receiver off while the sender keeps offering back-to-back, so
  // the result and command queues fill and full stalls the input.
  task automatic test_result_backpressure();
    set_taps(7'd8);
    tx_no_idle   = 1'b1;
    rx_hold_cnt <= PRESSURE_HOLD;
    for (int k = 0; k < 24; k++)
      push_item(cff_pkg::OP_SAMPLE, 6'($urandom), 16'($urandom), rand_word(),
                rand_word(), k == 0);
    tx_no_idle = 1'b0;
  endtask

  // Random phases, each with its own tap count. Most items are samples in
  // blocks of random length; loads retune the taps mid-stream, and a stray
  // block mark now and then breaks a run short.
  task automatic test_random_stream();
    logic [cff_pkg::TAPS_CFG_BITS-1:0] n;
    logic                              fob;
    int                                run_left;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       n = 7'd64;
        1:       n = 7'd1;
        2:       n = 7'($urandom_range(65, 127));
        3:       n = 7'd0;
        default: n = 7'($urandom_range(1, 64));
      endcase
      set_taps(n);
      run_left = 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k < 8 || $urandom_range(0, 99) < 10) begin
          push_item(cff_pkg::OP_LOAD, 6'($urandom), rand_word(), 16'($urandom),
                    16'($urandom), 1'($urandom));
        end else begin
          fob = (run_left == 0) || ($urandom_range(0, 49) == 0);
          if (fob)
            run_left = $urandom_range(1, 100);
          run_left--;
          push_item(cff_pkg::OP_SAMPLE, 6'($urandom), 16'($urandom), rand_word(),
                    rand_word(), fob);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            <= 1'b1;
    push           <= 1'b0;
    pop            <= 1'b0;
    opcode         <= cff_pkg::OP_LOAD;
    tap_index      <= '0;
    tap_value      <= '0;
    sample_i       <= '0;
    sample_q       <= '0;
    first_of_block <= 1'b0;
    taps_wr_en     <= 1'b0;
    taps_wr_data   <= '0;
    fir_model_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Hold off until the tap memory sweep after reset is done.
    while (full !== 1'b0) @(posedge clk);

    test_after_reset();
    test_single_tap_extremes();
    test_short_history();
    test_zero_taps();
    test_taps_above_max();
    test_result_backpressure();
    test_random_stream();

    settle_idle();
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/cff_pkg.sv
design/cff_ram.sv
design/cff_fifo.sv
design/cff_front.sv
design/cff_back.sv
design/complex_fir_filter.sv
verif/testbench.sv
